/* hdl/point_segment_distance_core_assert.svh */
// Assertion macros shared by the point-to-segment distance RTL.
`ifndef POINT_SEGMENT_DISTANCE_CORE_ASSERT_SVH
`define POINT_SEGMENT_DISTANCE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is applied.
`define PSD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("point_segment_distance_core: assertion failed");

// Next-cycle implication, disabled while reset is applied.
`define PSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("point_segment_distance_core: assertion failed");

`endif

/* hdl/psd_pkg.sv */
// Types and constants of the point-to-segment distance core.
`default_nettype none
package psd_pkg;

  localparam int COORD_BITS = 16;
  localparam int DIST_BITS  = 17;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int SUM_W      = PROD_W + 1;
  localparam int TGT_A      = 2 * SUM_W + 2;
  localparam int TGT_B      = SUM_W + 2 * DIST_BITS + 3;
  localparam int TGT_W      = (TGT_A > TGT_B) ? TGT_A : TGT_B;

  typedef enum logic [1:0] {
    CASE_START    = 2'd0,
    CASE_END      = 2'd1,
    CASE_INTERIOR = 2'd2
  } kind_e;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
  } psd_req_t;

  typedef struct packed {
    logic [DIST_BITS-1:0] distance;
    kind_e                nearest_case;
  } psd_rsp_t;

  // Root extraction state handed from cell to cell.
  typedef struct packed {
    logic [TGT_W-1:0]     rem;
    logic [TGT_W-1:0]     acc;
    logic [SUM_W-1:0]     scale;
    logic [DIST_BITS-1:0] root;
    kind_e                kind;
  } psd_work_t;

endpackage
`default_nettype wire

/* hdl/psd_front.sv */
// Front pipeline: differences, products, sums, case choice and root target.
`default_nettype none
module psd_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  output logic                    stall_o,
  input  wire psd_pkg::psd_req_t  req_i,
  output logic                    valid_o,
  input  wire logic               stall_i,
  output psd_pkg::psd_work_t      work_o
);

  localparam int DW = psd_pkg::DIFF_W;
  localparam int PW = psd_pkg::PROD_W;
  localparam int SW = psd_pkg::SUM_W;

  logic v1_q, v2_q, v3_q, v4_q;
  logic st1, st2, st3, st4;

  logic signed [DW-1:0] dx_q, dy_q, wx_q, wy_q, vx_q, vy_q;
  logic signed [PW-1:0] dwx_q, dwy_q, dxx_q, dyy_q, dxwy_q, dywx_q;
  logic signed [PW-1:0] wxx_q, wyy_q, vxx_q, vyy_q;
  logic signed [SW-1:0] dot_q, len2_q, cross_q, n0_q, n1_q;
  logic signed [2*SW-1:0] cross_sq;
  psd_pkg::psd_work_t   work_d, work_q;

  // Each stage holds while it is full and the next one is stalled.
  assign st4     = v4_q && stall_i;
  assign st3     = v3_q && st4;
  assign st2     = v2_q && st3;
  assign st1     = v1_q && st2;
  assign stall_o = st1;
  assign valid_o = v4_q;
  assign work_o  = work_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (!st1) v1_q <= valid_i;
      if (!st2) v2_q <= v1_q;
      if (!st3) v3_q <= v2_q;
      if (!st4) v4_q <= v3_q;
    end
  end

  // Stage one: coordinate differences.
  always_ff @(posedge clk_i) begin
    if (valid_i && !st1) begin
      dx_q <= DW'(req_i.end_x) - DW'(req_i.start_x);
      dy_q <= DW'(req_i.end_y) - DW'(req_i.start_y);
      wx_q <= DW'(req_i.point_x) - DW'(req_i.start_x);
      wy_q <= DW'(req_i.point_y) - DW'(req_i.start_y);
      vx_q <= DW'(req_i.point_x) - DW'(req_i.end_x);
      vy_q <= DW'(req_i.point_y) - DW'(req_i.end_y);
    end
  end

  // Stage two: all products.
  always_ff @(posedge clk_i) begin
    if (v1_q && !st2) begin
      dwx_q  <= dx_q * wx_q;
      dwy_q  <= dy_q * wy_q;
      dxx_q  <= dx_q * dx_q;
      dyy_q  <= dy_q * dy_q;
      dxwy_q <= dx_q * wy_q;
      dywx_q <= dy_q * wx_q;
      wxx_q  <= wx_q * wx_q;
      wyy_q  <= wy_q * wy_q;
      vxx_q  <= vx_q * vx_q;
      vyy_q  <= vy_q * vy_q;
    end
  end

  // Stage three: dot, squared length, cross and squared endpoint distances.
  always_ff @(posedge clk_i) begin
    if (v2_q && !st3) begin
      dot_q   <= SW'(dwx_q) + SW'(dwy_q);
      len2_q  <= SW'(dxx_q) + SW'(dyy_q);
      cross_q <= SW'(dxwy_q) - SW'(dywx_q);
      n0_q    <= SW'(wxx_q) + SW'(wyy_q);
      n1_q    <= SW'(vxx_q) + SW'(vyy_q);
    end
  end

  assign cross_sq = cross_q * cross_q;

  // Stage four: pick the nearest feature and set up the root search.
  always_comb begin
    work_d     = '0;
    work_d.acc = '0;
    if (dot_q[SW-1] || (dot_q == '0)) begin
      work_d.kind  = psd_pkg::CASE_START;
      work_d.rem   = psd_pkg::TGT_W'(unsigned'(n0_q));
      work_d.scale = SW'(1);
    end else if (len2_q <= dot_q) begin
      work_d.kind  = psd_pkg::CASE_END;
      work_d.rem   = psd_pkg::TGT_W'(unsigned'(n1_q));
      work_d.scale = SW'(1);
    end else begin
      work_d.kind  = psd_pkg::CASE_INTERIOR;
      work_d.rem   = psd_pkg::TGT_W'(unsigned'(cross_sq));
      work_d.scale = unsigned'(len2_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (v3_q && !st4) work_q <= work_d;
  end

endmodule
`default_nettype wire

/* hdl/psd_cell.sv */
// One root cell: decides one bit of the scaled square root.
`default_nettype none
module psd_cell #(
  parameter int BIT = 0
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  output logic                    stall_o,
  input  wire psd_pkg::psd_work_t work_i,
  output logic                    valid_o,
  input  wire logic               stall_i,
  output psd_pkg::psd_work_t      work_o
);

  localparam int TW = psd_pkg::TGT_W;

  logic               valid_q;
  logic [TW-1:0]      scale_w, delta;
  logic               take;
  psd_pkg::psd_work_t work_d, work_q;

  assign stall_o = valid_q && stall_i;
  assign valid_o = valid_q;
  assign work_o  = work_q;

  // Setting this bit grows q*q*s by (2*q*s + s*2^BIT) * 2^BIT.
  assign scale_w = TW'(work_i.scale);
  assign delta   = (work_i.acc << (BIT + 1)) + (scale_w << (2 * BIT));
  assign take    = work_i.rem >= delta;

  always_comb begin
    work_d = work_i;
    if (take) begin
      work_d.rem       = work_i.rem - delta;
      work_d.acc       = work_i.acc + (scale_w << BIT);
      work_d.root[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && !stall_o) work_q <= work_d;
  end

endmodule
`default_nettype wire

/* hdl/point_segment_distance_core.sv */
// Four front stages and 17 root cells lie between request and result.
// Throughput: one request per cycle while no stage stalls; the 17-cell root
// chain decides one bit per cell.
// Each stage holds only while it is full and its successor stalls, so bubbles
// are absorbed. Reset clears every valid bit asynchronously; data is not reset.
`default_nettype none
`include "point_segment_distance_core_assert.svh"
module point_segment_distance_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              req_valid_i,
  output logic                   req_stall_o,
  input  wire psd_pkg::psd_req_t req_i,
  output logic                   rsp_valid_o,
  input  wire logic              rsp_stall_i,
  output psd_pkg::psd_rsp_t      rsp_o
);

  localparam int NC = psd_pkg::DIST_BITS;

  logic               cv [NC+1];
  logic               cs [NC+1];
  psd_pkg::psd_work_t cw [NC+1];

  // Setup pipeline feeding the first cell.
  psd_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (req_valid_i),
    .stall_o (req_stall_o),
    .req_i   (req_i),
    .valid_o (cv[0]),
    .stall_i (cs[0]),
    .work_o  (cw[0])
  );

  // Chain of cells, most significant root bit first.
  for (genvar k = 0; k < NC; k++) begin : g_cell
    psd_cell #(.BIT(NC - 1 - k)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (cv[k]),
      .stall_o (cs[k]),
      .work_i  (cw[k]),
      .valid_o (cv[k+1]),
      .stall_i (cs[k+1]),
      .work_o  (cw[k+1])
    );
  end

  // The last cell's registers are the result register.
  assign cs[NC]             = rsp_stall_i;
  assign rsp_valid_o        = cv[NC];
  assign rsp_o.distance     = cw[NC].root;
  assign rsp_o.nearest_case = cw[NC].kind;

  // An endpoint case always searches with unit scale.
  `PSD_ASSERT_SAME(a_endpoint_scale, clk_i, rst_ni,
    cv[0] && (cw[0].kind != psd_pkg::CASE_INTERIOR), cw[0].scale == 1)
  // An interior case needs a segment of nonzero length.
  `PSD_ASSERT_SAME(a_interior_scale, clk_i, rst_ni,
    cv[0] && (cw[0].kind == psd_pkg::CASE_INTERIOR), cw[0].scale != '0)
  // The front only pushes back when the first root cell stalls it.
  `PSD_ASSERT_SAME(a_stall_full, clk_i, rst_ni, req_stall_o, cs[0])
  // A request entering the root chain starts with no bits decided.
  `PSD_ASSERT_SAME(a_root_clear, clk_i, rst_ni, cv[0], cw[0].root == '0)

endmodule
`default_nettype wire

/* dv/point_segment_distance_checker.sv */
// Checker for the point-to-segment distance core: predicts and compares results.
module point_segment_distance_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  input  logic               req_stall_i,
  input  psd_pkg::psd_req_t  req_i,
  input  logic               rsp_valid_i,
  input  logic               rsp_stall_i,
  input  psd_pkg::psd_rsp_t  rsp_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 checked_o,
  output int                 case_count_o [3]
);
  import psd_pkg::*;

  psd_rsp_t expected_rsps[$];
  int fail_count;
  int checked;
  int case_count [3];

  assign fail_count_o = fail_count;
  assign pending_o    = expected_rsps.size();
  assign checked_o    = checked;
  assign case_count_o = case_count;

  // Floored root of target/scale: largest q with q*q*scale <= target.
  function automatic logic [DIST_BITS-1:0] floor_root(logic [127:0] target,
                                                      logic [127:0] scale);
    logic [DIST_BITS-1:0] q;
    logic [DIST_BITS-1:0] t;
    logic [127:0] sq;
    q = '0;
    for (int b = DIST_BITS - 1; b >= 0; b--) begin
      t = q | (1 << b);
      sq = 128'(t) * 128'(t) * scale;
      if (sq <= target) q = t;
    end
    return q;
  endfunction

  // Computes the nearest-point distance and which part of the segment is nearest.
  function automatic psd_rsp_t segment_distance(psd_req_t r);
    psd_rsp_t o;
    longint dx, dy, wx, wy, fx, fy, dot, len2, cr;
    dx = longint'(r.end_x) - longint'(r.start_x);
    dy = longint'(r.end_y) - longint'(r.start_y);
    wx = longint'(r.point_x) - longint'(r.start_x);
    wy = longint'(r.point_y) - longint'(r.start_y);
    fx = longint'(r.point_x) - longint'(r.end_x);
    fy = longint'(r.point_y) - longint'(r.end_y);
    dot = dx * wx + dy * wy;
    len2 = dx * dx + dy * dy;
    if (dot <= 0) begin
      o.distance = floor_root(128'(wx * wx + wy * wy), 128'd1);
      o.nearest_case = CASE_START;
    end else if (len2 <= dot) begin
      o.distance = floor_root(128'(fx * fx + fy * fy), 128'd1);
      o.nearest_case = CASE_END;
    end else begin
      cr = dx * wy - dy * wx;
      if (cr < 0) cr = -cr;
      o.distance = floor_root(128'(cr) * 128'(cr), 128'(len2));
      o.nearest_case = CASE_INTERIOR;
    end
    return o;
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  // Queue predictions on accepted requests and compare accepted results.
  always @(posedge clk_i or negedge rst_ni) begin
    psd_rsp_t want;
    if (!rst_ni) begin
      expected_rsps.delete();
      fail_count <= 0;
      checked <= 0;
      case_count <= '{0, 0, 0};
    end else begin
      if (req_valid_i && !req_stall_i) expected_rsps.push_back(segment_distance(req_i));
      if (rsp_valid_i && !rsp_stall_i) begin
        if (expected_rsps.size() == 0) begin
          report_mismatch("result with no request waiting");
        end else begin
          want = expected_rsps.pop_front();
          checked <= checked + 1;
          if (want.nearest_case <= CASE_INTERIOR)
            case_count[want.nearest_case] <= case_count[want.nearest_case] + 1;
          if (rsp_i.distance !== want.distance)
            report_mismatch($sformatf("distance %0d, expected %0d",
                                      rsp_i.distance, want.distance));
          if (rsp_i.nearest_case !== want.nearest_case)
            report_mismatch($sformatf("nearest_case %0d, expected %0d",
                                      rsp_i.nearest_case, want.nearest_case));
        end
      end
    end
  end
endmodule

/* dv/point_segment_distance_core_test.sv */
// Testbench top for the point-to-segment distance core: stimulus and verdict.
module point_segment_distance_core_test;
  import psd_pkg::*;

  localparam int RANDOM_REQS = 1200;
  localparam int CYCLE_LIMIT = 200000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic req_valid_i = 1'b0;
  logic req_stall_o;
  psd_req_t req_i = '0;
  logic rsp_valid_o;
  logic rsp_stall_i = 1'b0;
  psd_rsp_t rsp_o;
  int fail_count, pending, checked;
  int case_count [3];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int cycles = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  point_segment_distance_core dut (
    .clk_i, .rst_ni, .req_valid_i, .req_stall_o, .req_i,
    .rsp_valid_o, .rsp_stall_i, .rsp_o
  );

  point_segment_distance_checker checker_i (
    .clk_i, .rst_ni, .req_valid_i, .req_stall_i(req_stall_o), .req_i,
    .rsp_valid_i(rsp_valid_o), .rsp_stall_i, .rsp_i(rsp_o),
    .fail_count_o(fail_count), .pending_o(pending), .checked_o(checked),
    .case_count_o(case_count)
  );

  // Receiver stalls at random at the current rate.
  always @(posedge clk_i) begin
    rsp_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // Watchdog on total run length.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($signed($urandom_range(64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  // Sends one request, with optional idle cycles, and waits until it is taken.
  task automatic send_request(psd_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    req_valid_i <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (req_stall_o) @(posedge clk_i);
  endtask

  task automatic send_segment(int px, int py, int sx, int sy, int ex, int ey);
    psd_req_t r;
    r.point_x = 16'(px);
    r.point_y = 16'(py);
    r.start_x = 16'(sx);
    r.start_y = 16'(sy);
    r.end_x = 16'(ex);
    r.end_y = 16'(ey);
    send_request(r);
  endtask

  initial begin
    psd_req_t r;
    int c;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: each nearest case, a degenerate segment, boundary projections
    // and the coordinate extremes, including the longest possible distance.
    send_segment(0, 0, 0, 0, 0, 0);
    send_segment(100, -50, 16, 16, 16, 16);
    send_segment(-32, 5, 0, 0, 64, 0);
    send_segment(0, 7, 0, 0, 64, 0);
    send_segment(64, 7, 0, 0, 64, 0);
    send_segment(100, 7, 0, 0, 64, 0);
    send_segment(32, 33, 0, 0, 64, 0);
    send_segment(20, -3, 0, 0, 40, 30);
    send_segment(-32768, -32768, 32767, 32767, 32767, 32767);
    send_segment(32767, 32767, -32768, -32768, -32768, -32768);
    send_segment(-32768, 32767, 32767, -32768, 32767, -32768);
    send_segment(32767, -32768, -32768, -32768, 32767, 32767);
    send_segment(-32768, 32767, -32768, -32768, 32767, 32767);
    send_segment(0, 0, -32768, -32768, 32767, 32767);
    send_segment(32767, 32767, -32768, -32768, 32767, -32768);
    send_segment(1, 1, 0, 0, 3, 2);
    send_segment(-1, -1, 1, 1, 0, 0);
    send_segment(-21846, 21845, 21845, -21846, 10, -10);

    // Random: three phases of idling, mostly full-range coordinates plus small values and extremes.
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 22 : (phase == 1) ? 54 : 0;
      recv_idle_pct = (phase == 0) ? 54 : (phase == 1) ? 22 : 0;
      for (int i = 0; i < RANDOM_REQS / 3; i++) begin
        if ($urandom_range(3) == 0) begin
          r = psd_req_t'({$urandom, $urandom, $urandom});
        end else begin
          r.point_x = rand_coord();
          r.point_y = rand_coord();
          r.start_x = rand_coord();
          r.start_y = rand_coord();
          c = $urandom_range(7);
          r.end_x = (c == 0) ? r.start_x : rand_coord();
          r.end_y = (c == 0) ? r.start_y : rand_coord();
        end
        send_request(r);
      end
    end
    req_valid_i <= 1'b0;

    // Drain: wait for outstanding results, then for the pipeline depth.
    while (pending != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);

    $display("checked %0d results: %0d start, %0d end, %0d interior nearest",
             checked, case_count[0], case_count[1], case_count[2]);
    $display("three idling phases run, %0d mismatches", fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

/* point_segment_distance_core.f */
+incdir+hdl
hdl/psd_pkg.sv
hdl/psd_front.sv
hdl/psd_cell.sv
hdl/point_segment_distance_core.sv
dv/point_segment_distance_checker.sv
dv/point_segment_distance_core_test.sv
